/* rtl/core/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// Shared widths, limits and status codes of the thermocouple rolling average.
// ----------------------------------------------------------------------------
package tra_pkg;

    localparam int TRA_WINDOW = 4;

    localparam int WORD_W  = 16;
    localparam int VAL_W   = 14;
    localparam int AVG_W   = 16;
    localparam int FAULT_W = 16;
    localparam int STAT_W  = 2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [FAULT_W-1:0]      FAULT_SAT = {FAULT_W{1'b1}};

    localparam logic [STAT_W-1:0] ST_NONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_VALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAULTED = 2'd2;

endpackage

/* rtl/core/tra_if.sv */
// ----------------------------------------------------------------------------
// tra_if
// Valid/ready channels: converter beats in, average result beats out.
// ----------------------------------------------------------------------------
interface tra_in_if;
    import tra_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] sensor_word;
    logic              transfer_ok;

    modport source (output valid, output sensor_word, output transfer_ok, input ready);
    modport sink   (input valid, input sensor_word, input transfer_ok, output ready);
endinterface

interface tra_out_if;
    import tra_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        average_status;
    logic signed [AVG_W-1:0]  average_sixteenths;
    logic                     extremes_valid;
    logic signed [VAL_W-1:0]  min_quarters;
    logic signed [VAL_W-1:0]  max_quarters;
    logic [FAULT_W-1:0]       fault_count;

    modport source (
        output valid, output average_status, output average_sixteenths,
        output extremes_valid, output min_quarters, output max_quarters,
        output fault_count, input ready
    );
    modport sink (
        input valid, input average_status, input average_sixteenths,
        input extremes_valid, input min_quarters, input max_quarters,
        input fault_count, output ready
    );
endinterface

/* rtl/core/tra_div.sv */
// ----------------------------------------------------------------------------
// tra_div
// Iterative floor divider: signed dividend by small unsigned count,
// one quotient bit per cycle, sign and floor fix in a final state.
// ----------------------------------------------------------------------------
module tra_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]                  i_den,
    output logic                              o_done,
    output logic signed [tra_pkg::AVG_W-1:0]  o_quot
);
    import tra_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate            r_state;
    logic [CW-1:0]      r_cnt;
    logic [NUM_W-1:0]   r_quo;
    logic [DEN_W:0]     r_rem;
    logic [DEN_W-1:0]   r_den;
    logic               r_neg;
    logic               r_done;
    logic signed [AVG_W-1:0] r_quot;

    logic [DEN_W:0]     rem_sh;
    logic               ge;
    logic [NUM_W-1:0]   num_mag;
    logic [NUM_W:0]     fix_val;

    assign num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign rem_sh  = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign fix_val = r_neg ? ((NUM_W+1)'(0) - {1'b0, r_quo} - (NUM_W+1)'(r_rem != '0))
                           : {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == D_FIX);
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                        r_cnt   <= '0;
                    end
                end
                D_RUN: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NUM_W - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end else if (r_state == D_RUN) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        end
        if (r_state == D_FIX) begin
            r_quot <= fix_val[AVG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/thermocouple_rolling_average_unit.sv */
// ----------------------------------------------------------------------------
// thermocouple_rolling_average_unit
// Rolling average of thermocouple readings with fault skip and min/max.
// ----------------------------------------------------------------------------
// One beat is taken at a time. During warm-up a beat goes from idle straight
// to the done state; after that it passes the ring scan at one entry per
// cycle, the evaluate state and the divider at one quotient bit per cycle,
// NUM_W = 16 + clog2(WINDOW). When no ring entry is valid the divider is
// skipped. A finished result sits in the output register while the next beat
// is taken; a beat whose result is still waiting stalls in its final state
// until the output register frees.
module thermocouple_rolling_average_unit #(
    parameter int WINDOW = tra_pkg::TRA_WINDOW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tra_in_if.sink     i_in,
    tra_out_if.source  o_out
);
    import tra_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = VAL_W + IDX_W;
    localparam int NUM_W = SUM_W + 2;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EVAL, S_WAIT, S_DONE} t_state;

    t_state                  r_state;
    logic                    r_ring_val [WINDOW];
    logic signed [VAL_W-1:0] r_ring_dat [WINDOW];
    logic [IDX_W-1:0]        r_slot;
    logic [CNT_W-1:0]        r_warm;
    logic signed [AVG_W-1:0] r_avg;
    logic [STAT_W-1:0]       r_avg_st;
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;
    logic                    r_seen;
    logic [FAULT_W-1:0]      r_faults;
    logic [IDX_W-1:0]        r_idx;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_n;
    logic                    r_out_valid;
    logic                    r_div_start;

    logic [STAT_W-1:0]       r_o_status;
    logic signed [AVG_W-1:0] r_o_avg;
    logic                    r_o_seen;
    logic signed [VAL_W-1:0] r_o_min;
    logic signed [VAL_W-1:0] r_o_max;
    logic [FAULT_W-1:0]      r_o_faults;

    logic                    in_fire;
    logic                    rd_ok;
    logic                    cur_val;
    logic signed [VAL_W-1:0] cur_dat;
    logic                    out_free;
    logic                    div_done;
    logic signed [AVG_W-1:0] div_quot;

    assign in_fire  = i_in.valid && i_in.ready;
    assign rd_ok    = i_in.transfer_ok && !i_in.sensor_word[0];
    assign cur_val  = r_ring_val[r_idx];
    assign cur_dat  = r_ring_dat[r_idx];
    assign out_free = !r_out_valid || o_out.ready;

    tra_div #(
        .NUM_W (NUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   ($signed({r_sum, 2'b00})),
        .i_den   (r_n),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_warm      <= '0;
            r_avg       <= '0;
            r_avg_st    <= ST_NONE;
            r_min       <= VAL_MAX;
            r_max       <= VAL_MIN;
            r_seen      <= 1'b0;
            r_faults    <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring_val[k] <= 1'b0;
            end
        end else begin
            r_div_start <= (r_state == S_EVAL) && (r_n != '0);
            r_out_valid <= (r_state == S_DONE && out_free) || (r_out_valid && !o_out.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_ring_val[r_slot] <= rd_ok;
                        r_slot <= (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + IDX_W'(1);
                        if (r_warm < CNT_W'(WINDOW)) begin
                            r_warm <= r_warm + CNT_W'(1);
                        end
                        if (r_warm >= CNT_W'(WINDOW - 1)) begin
                            r_idx   <= '0;
                            r_n     <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (cur_val) begin
                        r_n    <= r_n + CNT_W'(1);
                        r_seen <= 1'b1;
                        if (cur_dat < r_min) begin
                            r_min <= cur_dat;
                        end
                        if (cur_dat > r_max) begin
                            r_max <= cur_dat;
                        end
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(WINDOW - 1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_n == '0) begin
                        r_avg    <= '0;
                        r_avg_st <= ST_FAULTED;
                        if (r_faults != FAULT_SAT) begin
                            r_faults <= r_faults + FAULT_W'(1);
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_avg    <= div_quot;
                        r_avg_st <= ST_VALID;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_fire) begin
            r_ring_dat[r_slot] <= $signed(i_in.sensor_word[WORD_W-1:2]);
            r_sum <= '0;
        end else if (r_state == S_SCAN && cur_val) begin
            r_sum <= r_sum + SUM_W'(cur_dat);
        end
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_avg_st;
            r_o_avg    <= r_avg;
            r_o_seen   <= r_seen;
            r_o_min    <= r_min;
            r_o_max    <= r_max;
            r_o_faults <= r_faults;
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_out_valid;
    assign o_out.average_status     = r_o_status;
    assign o_out.average_sixteenths = r_o_avg;
    assign o_out.extremes_valid     = r_o_seen;
    assign o_out.min_quarters       = r_o_min;
    assign o_out.max_quarters       = r_o_max;
    assign o_out.fault_count        = r_o_faults;

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_WAIT)
        else $error("divider finished outside wait state");

    a_extremes_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> r_min <= r_max)
        else $error("min above max after a valid reading");

    a_average_after_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg_st != ST_NONE |-> r_warm == CNT_W'(WINDOW))
        else $error("average state set before warm-up complete");

    a_faulted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg_st == ST_FAULTED |-> r_avg == '0)
        else $error("faulted average not zero");

    a_faults_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_faults >= $past(r_faults))
        else $error("fault count decreased");

endmodule

/* verif/tra_average_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tra_average_checker
// Watches the converter and result channels of the rolling average unit,
// predicts every result from the accepted readings and compares it field by
// field. Hands its mismatch count and the number of outstanding results to
// the testbench top.
// ----------------------------------------------------------------------------
module tra_average_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tra_in_if    i_in_mon,
    tra_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import tra_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [AVG_W-1:0] avg;
        logic                    ext;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic [FAULT_W-1:0]      faults;
    } t_avg_result;

    // ring entry: bit VAL_W is the valid flag, below it the reading
    logic [VAL_W:0]          ring_q [TRA_WINDOW];
    int                      slot_q;
    int                      warm_q;
    logic signed [AVG_W-1:0] avg_q;
    logic [STAT_W-1:0]       stat_q;
    logic signed [VAL_W-1:0] lo_q;
    logic signed [VAL_W-1:0] hi_q;
    logic                    seen_q;
    logic [FAULT_W-1:0]      faults_q;

    t_avg_result expected_results[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic fold_reading(input logic [WORD_W-1:0] word, input logic ok,
                                output t_avg_result r);
        int sum;
        int n;
        int t;
        int q;
        ring_q[slot_q] = (ok && !word[0]) ? {1'b1, word[WORD_W-1:2]} : '0;
        slot_q = (slot_q + 1) % TRA_WINDOW;
        if (warm_q < TRA_WINDOW) warm_q++;
        if (warm_q >= TRA_WINDOW) begin
            sum = 0;
            n = 0;
            for (int i = 0; i < TRA_WINDOW; i++) begin
                if (ring_q[i][VAL_W]) begin
                    t = $signed(ring_q[i][VAL_W-1:0]);
                    sum += t;
                    n++;
                    if (t > hi_q) hi_q = t[VAL_W-1:0];
                    if (t < lo_q) lo_q = t[VAL_W-1:0];
                    seen_q = 1'b1;
                end
            end
            if (n > 0) begin
                // floor division, the quotient rounds toward minus infinity
                q = (4 * sum) / n;
                if ((4 * sum) % n != 0 && sum < 0) q--;
                avg_q  = q[AVG_W-1:0];
                stat_q = ST_VALID;
            end else begin
                avg_q  = '0;
                stat_q = ST_FAULTED;
                if (faults_q != FAULT_SAT) faults_q++;
            end
        end
        r = '{stat_q, avg_q, seen_q, lo_q, hi_q, faults_q};
    endtask

    always @(posedge i_clk) begin : watch
        t_avg_result got;
        t_avg_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < TRA_WINDOW; i++) ring_q[i] = '0;
            slot_q   = 0;
            warm_q   = 0;
            avg_q    = '0;
            stat_q   = ST_NONE;
            lo_q     = VAL_MAX;
            hi_q     = VAL_MIN;
            seen_q   = 1'b0;
            faults_q = '0;
            expected_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = '{i_out_mon.average_status, i_out_mon.average_sixteenths,
                        i_out_mon.extremes_valid, i_out_mon.min_quarters,
                        i_out_mon.max_quarters, i_out_mon.fault_count};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat, status", got.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("average_status", got.status, want.status);
                    if (got.avg !== want.avg)
                        report_mismatch("average_sixteenths", $signed(got.avg),
                                        $signed(want.avg));
                    if (got.ext !== want.ext)
                        report_mismatch("extremes_valid", got.ext, want.ext);
                    if (got.lo !== want.lo)
                        report_mismatch("min_quarters", $signed(got.lo), $signed(want.lo));
                    if (got.hi !== want.hi)
                        report_mismatch("max_quarters", $signed(got.hi), $signed(want.hi));
                    if (got.faults !== want.faults)
                        report_mismatch("fault_count", got.faults, want.faults);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                fold_reading(i_in_mon.sensor_word, i_in_mon.transfer_ok, want);
                expected_results.push_back(want);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* verif/thermocouple_rolling_average_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermocouple_rolling_average_unit_tb
// Drives converter beats into the rolling average unit: a directed opening
// (warm-up, all-faulted window, reading extremes, floor rounding of negative
// averages) followed by random beats with drifting temperatures, noise and
// fault bursts. Both channels idle in random bursts; the receiver once holds
// off for a long stretch. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module thermocouple_rolling_average_unit_tb;
    import tra_pkg::*;

    localparam int RANDOM_BEATS = 1525;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bit idle_on    = 1'b0;
    bit hold_go    = 1'b0;
    int stall_left = 0;
    int burst_left = 0;
    int cycles     = 0;
    int fail_count;
    int pending;

    tra_in_if  in_ch ();
    tra_out_if out_ch ();

    thermocouple_rolling_average_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tra_average_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("thermocouple_rolling_average_unit_tb NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go <= 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 7) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [WORD_W-1:0] word, input logic ok);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sensor_word <= word;
        in_ch.transfer_ok <= ok;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int                mode;
        int                temp;
        int                v;
        logic [WORD_W-1:0] w;
        logic              ok;

        in_ch.valid       = 1'b0;
        in_ch.sensor_word = '0;
        in_ch.transfer_ok = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on <= 1'b1;

        // warm-up with nothing valid, first average sees an all-faulted ring
        send_beat(16'h0000, 1'b0);
        send_beat(16'h7FFD, 1'b1);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0001, 1'b1);
        send_beat(16'h8001, 1'b1);
        // reading extremes, bit 1 both ways
        send_beat(16'h7FFC, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h7FFE, 1'b1);
        send_beat(16'h8002, 1'b1);
        repeat (4) send_beat(16'h7FFC, 1'b1);
        repeat (4) send_beat(16'h8000, 1'b1);
        // partial windows: negative sum over three, then positive sums over three and two
        send_beat(16'hFFFC, 1'b1);
        send_beat(16'h0000, 1'b1);
        send_beat(16'h0000, 1'b1);
        send_beat(16'h0001, 1'b1);
        send_beat(16'h0004, 1'b1);
        send_beat(16'h0004, 1'b0);
        wait_drained();

        temp = 0;
        mode = 1;
        for (int beat = 0; beat < RANDOM_BEATS; beat++) begin
            if (beat % 24 == 0) mode = $urandom_range(0, 5);
            if (beat == 400) hold_go <= 1'b1;
            if (beat == 700) wait_drained();
            if (beat == 800) idle_on <= 1'b0;
            if (beat == 950) idle_on <= 1'b1;
            if (beat == RANDOM_BEATS - 200) idle_on <= 1'b0;

            temp = temp + $urandom_range(0, 64) - 32;
            if (temp > 8191) temp = 8191;
            if (temp < -8192) temp = -8192;
            v  = temp;
            ok = 1'b1;
            if (mode == 5) begin
                case ($urandom_range(0, 2))
                    0: v = 8191;
                    1: v = -8192;
                    default: v = $urandom_range(0, 16383) - 8192;
                endcase
            end
            w = {v[VAL_W-1:0], 1'($urandom_range(0, 1)), 1'b0};
            case (mode)
                0: begin
                    w  = WORD_W'($urandom_range(0, 65535));
                    ok = 1'($urandom_range(0, 1));
                end
                4: begin
                    if ($urandom_range(0, 7) != 0) begin
                        if ($urandom_range(0, 1)) ok = 1'b0;
                        else w[0] = 1'b1;
                    end
                end
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        if ($urandom_range(0, 1)) ok = 1'b0;
                        else w[0] = 1'b1;
                    end
                end
            endcase
            send_beat(w, ok);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("thermocouple_rolling_average_unit_tb OK");
        end else begin
            $display("thermocouple_rolling_average_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
